/* src/fmbf_pkg.sv */
// shared types and constants of the mirrored-boundary fir filter
package fmbf_pkg;

	localparam int CHANNELS = 6;
	// accumulator: up to 127 products of 32 x 32 bits
	localparam int ACC_W    = 72;
	// tap sum: up to 127 taps of 32 bits
	localparam int TSUM_W   = 40;
	// rounding numerator 2|acc| + |tsum|
	localparam int NUM_W    = ACC_W + 1;
	localparam int CNT_W    = $clog2(NUM_W);
	// signed width for mirrored positions
	localparam int POS_W    = 17;

	localparam logic [1:0] CFG_TAP_COUNT    = 2'd0;
	localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd1;

	typedef enum logic [1:0] {
		MODE_TAP   = 2'd0,
		MODE_REC   = 2'd1,
		MODE_QUERY = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_SUM = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MAC,
		S_DRAIN,
		S_DIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic clear;
		logic mac_en;
		logic div_start;
	} lane_ctrl_t;

endpackage

/* src/fmbf_ram.sv */
// generic single-write, single-read ram with registered read data
module fmbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/fmbf_lane.sv */
// one channel lane: multiply-accumulate and rounding divide by the tap sum
module fmbf_lane import fmbf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lane_ctrl_t               ctrl,
	input  logic signed [31:0]       tap,
	input  logic signed [31:0]       smp,
	input  logic signed [TSUM_W-1:0] tsum,
	output logic                     done,
	output logic signed [31:0]       result
);

	logic signed [63:0]      prod_s2;
	logic                    prod_v_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic [NUM_W-1:0]        num_q;
	logic [TSUM_W:0]         den2_q;
	logic [TSUM_W:0]         rem_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    neg_q;
	logic                    done_q;
	logic [ACC_W-1:0]        acc_abs;
	logic [TSUM_W-1:0]       tsum_abs;
	logic [TSUM_W+1:0]       trial;
	logic                    fits;

	// magnitudes for the divide start and the trial subtraction of the divider
	always_comb begin
		acc_abs  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		tsum_abs = tsum[TSUM_W-1] ? TSUM_W'(-tsum) : TSUM_W'(tsum);
		trial    = {rem_q, num_q[NUM_W-1]};
		fits     = trial >= {1'b0, den2_q};
	end

	// control of the mac pipeline and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s2 <= 1'b0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			prod_v_s2 <= ctrl.mac_en && !ctrl.clear;
			done_q    <= 1'b0;
			if (ctrl.div_start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// product, accumulator and restoring divide datapath
	always_ff @(posedge clk) begin
		if (ctrl.mac_en) begin
			prod_s2 <= tap * smp;
		end
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (ctrl.div_start) begin
			num_q  <= {acc_abs, 1'b0} + NUM_W'(tsum_abs);
			den2_q <= {tsum_abs, 1'b0};
			rem_q  <= '0;
			neg_q  <= acc_q[ACC_W-1] ^ tsum[TSUM_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? TSUM_W'(trial - {1'b0, den2_q}) + (TSUM_W+1)'(0)
			              : trial[TSUM_W:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	// saturate the rounded quotient to 32 bits
	always_comb begin
		if (neg_q) begin
			result = (num_q > NUM_W'(33'h0_8000_0000)) ? 32'sh8000_0000
			                                            : -$signed(num_q[31:0]);
		end else begin
			result = (num_q > NUM_W'(33'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF
			                                            : $signed(num_q[31:0]);
		end
	end

	assign done = done_q;

endmodule

/* src/fir_mirror_boundary_filter.sv */
// top level: record stores, query sequencer, six channel lanes and result merge
//
// Channels: an input channel (in_valid / in_ready) carries one item with a mode.
// Mode 0 writes a tap, mode 1 writes a six-channel record with its time tag,
// mode 2 queries the filtered record at sample_index, mode 3 is dropped.
// A configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) sets
// the tap count (index 0) and the record count (index 1); it is always ready.
// Results leave on out_valid / out_ready, one per query, through an output
// register.
// Loads are taken while idle. A query runs in order: a range check, a tap walk
// through the tap and record memory read ports, a pipeline drain, the
// one-bit-per-cycle divider in each lane, and the load of the output register.
// A query that fails the range check, or whose tap sum is zero, goes straight
// from the check or the drain to the output register.
// Reset clears the control state and sets both count registers to 1;
// memory contents stay undefined until written, and no clearing pass runs.
// When the receiver stalls, the result waits in the output register; loads
// are still accepted, and a following query completes its work then waits
// until the output register is free.
module fir_mirror_boundary_filter import fmbf_pkg::*; #(
	parameter int MAX_TAPS    = 128,
	parameter int MAX_SAMPLES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [6:0]         tap_index,
	input  logic signed [31:0] tap_value,
	input  logic [11:0]        sample_index,
	input  logic signed [31:0] sat_roll,
	input  logic signed [31:0] sat_pitch,
	input  logic signed [31:0] sat_yaw,
	input  logic signed [31:0] prec_roll,
	input  logic signed [31:0] prec_pitch,
	input  logic signed [31:0] prec_yaw,
	input  logic [63:0]        time_tag,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [12:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] sat_roll_out,
	output logic signed [31:0] sat_pitch_out,
	output logic signed [31:0] sat_yaw_out,
	output logic signed [31:0] prec_roll_out,
	output logic signed [31:0] prec_pitch_out,
	output logic signed [31:0] prec_yaw_out,
	output logic [63:0]        time_tag_out,
	output logic [11:0]        centre_index,
	output logic [1:0]         status
);

	localparam int TA_W = $clog2(MAX_TAPS);
	localparam int SA_W = $clog2(MAX_SAMPLES);

	state_t                  state_q, state_d;
	logic [6:0]              tap_count_q;
	logic [12:0]             rec_count_q;
	logic [11:0]             c_q;
	logic                    c_in_q;
	logic [6:0]              m_q;
	logic [6:0]              k_q;
	logic signed [POS_W-1:0] p_q;
	logic signed [POS_W-1:0] n_q;
	logic signed [POS_W-1:0] j;
	logic [1:0]              drain_q;
	logic                    rd_v_s1;
	logic signed [TSUM_W-1:0] tsum_q;
	status_t                 status_q;
	logic                    issue;
	logic                    out_load;
	lane_ctrl_t              lane_ctrl;
	logic                    in_xfer;
	logic                    tap_we, rec_we;
	logic [6:0]              m_c;
	logic [POS_W-1:0]        c_u, h_u, n_u;
	logic                    range_bad;
	logic [31:0]             tap_rd;
	logic [63:0]             time_rd;
	logic [31:0]             smp_wr [CHANNELS];
	logic [31:0]             smp_rd [CHANNELS];
	logic signed [31:0]      lane_res [CHANNELS];
	logic [CHANNELS-1:0]     lane_done;
	logic signed [31:0]      chan_q [CHANNELS];
	logic                    out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign tap_we    = in_xfer && (mode_t'(mode) == MODE_TAP)
	                   && ({4'b0, tap_index} < 11'(MAX_TAPS));
	assign rec_we    = in_xfer && (mode_t'(mode) == MODE_REC)
	                   && ({5'b0, sample_index} < 17'(MAX_SAMPLES));

	assign smp_wr[0] = sat_roll;
	assign smp_wr[1] = sat_pitch;
	assign smp_wr[2] = sat_yaw;
	assign smp_wr[3] = prec_roll;
	assign smp_wr[4] = prec_pitch;
	assign smp_wr[5] = prec_yaw;

	// tap count in use and range check of the mirrored window
	always_comb begin
		m_c = ({4'b0, tap_count_q} > 11'(MAX_TAPS)) ? 7'(MAX_TAPS) : tap_count_q;
		if (m_c != 7'd0 && !m_c[0]) begin
			m_c = m_c - 7'd1;
		end
		c_u = POS_W'(c_q);
		h_u = POS_W'(m_c[6:1]);
		n_u = ({4'b0, rec_count_q} > 17'(MAX_SAMPLES)) ? POS_W'(MAX_SAMPLES)
		                                              : POS_W'(rec_count_q);
		range_bad = (c_u >= n_u)
		            || ((h_u > c_u) && ((h_u - c_u) >= n_u))
		            || ((c_u + h_u) >= {n_u[POS_W-2:0], 1'b0});
	end

	// mirrored record index for the current tap
	always_comb begin
		if (p_q < 0) begin
			j = -p_q;
		end else if (p_q >= n_q) begin
			j = (n_q <<< 1) - p_q - POS_W'(1);
		end else begin
			j = p_q;
		end
	end

	// next state and sequencer outputs
	always_comb begin
		state_d   = state_q;
		issue     = 1'b0;
		out_load  = 1'b0;
		lane_ctrl = '{clear: 1'b0, mac_en: rd_v_s1, div_start: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer && mode_t'(mode) == MODE_QUERY) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				lane_ctrl.clear = 1'b1;
				state_d = range_bad ? S_OUT : S_MAC;
			end
			S_MAC: begin
				if (k_q == m_q) begin
					state_d = S_DRAIN;
				end else begin
					issue = 1'b1;
				end
			end
			S_DRAIN: begin
				if (drain_q == 2'd2) begin
					if (tsum_q == '0) begin
						state_d = S_OUT;
					end else begin
						lane_ctrl.div_start = 1'b1;
						state_d = S_DIV;
					end
				end
			end
			S_DIV: begin
				if (lane_done[0]) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state, configuration and handshake registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tap_count_q <= 7'd1;
			rec_count_q <= 13'd1;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TAP_COUNT) begin
					tap_count_q <= cfg_data[6:0];
				end else if (cfg_index == CFG_SAMPLE_COUNT) begin
					rec_count_q <= cfg_data;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// query datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			c_q    <= sample_index;
			c_in_q <= {5'b0, sample_index} < 17'(MAX_SAMPLES);
		end
		if (state_q == S_CHECK) begin
			m_q      <= m_c;
			k_q      <= '0;
			p_q      <= $signed(c_u) - $signed(h_u);
			n_q      <= $signed(n_u);
			tsum_q   <= '0;
			status_q <= range_bad ? ST_RANGE : ST_OK;
		end
		if (issue) begin
			k_q <= k_q + 7'd1;
			p_q <= p_q + POS_W'(1);
		end
		if (state_q == S_MAC) begin
			drain_q <= '0;
		end else if (state_q == S_DRAIN) begin
			drain_q <= drain_q + 2'd1;
			if (drain_q == 2'd2 && tsum_q == '0) begin
				status_q <= ST_ZERO_SUM;
			end
		end
		if (rd_v_s1) begin
			tsum_q <= tsum_q + TSUM_W'($signed(tap_rd));
		end
	end

	// result merge into the output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < CHANNELS; i++) begin
				chan_q[i] <= (status_q == ST_OK) ? lane_res[i] : 32'sd0;
			end
			time_tag_out <= c_in_q ? time_rd : 64'd0;
			centre_index <= c_q;
			status       <= status_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign sat_roll_out   = chan_q[0];
	assign sat_pitch_out  = chan_q[1];
	assign sat_yaw_out    = chan_q[2];
	assign prec_roll_out  = chan_q[3];
	assign prec_pitch_out = chan_q[4];
	assign prec_yaw_out   = chan_q[5];

	// tap table
	fmbf_ram #(.WIDTH(32), .DEPTH(MAX_TAPS)) u_tap_ram (
		.clk   (clk),
		.we    (tap_we),
		.waddr (TA_W'(tap_index)),
		.wdata (tap_value),
		.re    (issue),
		.raddr (TA_W'(k_q)),
		.rdata (tap_rd)
	);

	// time tag store, read at the centre
	fmbf_ram #(.WIDTH(64), .DEPTH(MAX_SAMPLES)) u_time_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (SA_W'(sample_index)),
		.wdata (time_tag),
		.re    (state_q == S_CHECK),
		.raddr (SA_W'(c_q)),
		.rdata (time_rd)
	);

	// one record store and one lane per channel
	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		fmbf_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_smp_ram (
			.clk   (clk),
			.we    (rec_we),
			.waddr (SA_W'(sample_index)),
			.wdata (smp_wr[g]),
			.re    (issue),
			.raddr (SA_W'(unsigned'(j))),
			.rdata (smp_rd[g])
		);

		fmbf_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl),
			.tap    ($signed(tap_rd)),
			.smp    ($signed(smp_rd[g])),
			.tsum   (tsum_q),
			.done   (lane_done[g]),
			.result (lane_res[g])
		);
	end

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (sat_roll_out == 0) && (sat_pitch_out == 0)
		&& (sat_yaw_out == 0) && (prec_roll_out == 0) && (prec_pitch_out == 0)
		&& (prec_yaw_out == 0))
		else $error("error result with nonzero channel");
	a_done_div: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> (state_q == S_DIV))
		else $error("divider finished outside divide phase");
	a_rd_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (state_q == S_MAC) || (state_q == S_DRAIN))
		else $error("tap read outside tap walk");
	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> (lane_done == {CHANNELS{1'b1}}))
		else $error("lanes out of step");
`endif

endmodule

/* test/fir_mirror_boundary_filter_tb.sv */
// testbench for the mirrored-boundary fir filter: directed table, then random phases
`timescale 1ns / 1ps

module fir_mirror_boundary_filter_tb;
	import fmbf_pkg::*;

	localparam int NTAPS = 128;
	localparam int NREC  = 4096;

	typedef enum logic [0:0] {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		mode_t            md;
		logic [6:0]       tidx;
		logic [31:0]      tval;
		logic [11:0]      sidx;
		logic [5:0][31:0] chan;
		logic [63:0]      tag;
		logic             lit;
		status_t          lit_st;
		logic [1:0]       reg_idx;
		logic [12:0]      reg_val;
	} stim_t;

	typedef struct packed {
		logic [5:0][31:0] chan;
		logic [63:0]      tag;
		logic [11:0]      centre;
		status_t          st;
	} filt_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         mode;
	logic [6:0]         tap_index;
	logic signed [31:0] tap_value;
	logic [11:0]        sample_index;
	logic signed [31:0] sat_roll, sat_pitch, sat_yaw;
	logic signed [31:0] prec_roll, prec_pitch, prec_yaw;
	logic [63:0]        time_tag;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [12:0]        cfg_data;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] sat_roll_out, sat_pitch_out, sat_yaw_out;
	logic signed [31:0] prec_roll_out, prec_pitch_out, prec_yaw_out;
	logic [63:0]        time_tag_out;
	logic [11:0]        centre_index;
	logic [1:0]         status;

	fir_mirror_boundary_filter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode),
		.tap_index(tap_index), .tap_value(tap_value), .sample_index(sample_index),
		.sat_roll(sat_roll), .sat_pitch(sat_pitch), .sat_yaw(sat_yaw),
		.prec_roll(prec_roll), .prec_pitch(prec_pitch), .prec_yaw(prec_yaw),
		.time_tag(time_tag),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.sat_roll_out(sat_roll_out), .sat_pitch_out(sat_pitch_out),
		.sat_yaw_out(sat_yaw_out), .prec_roll_out(prec_roll_out),
		.prec_pitch_out(prec_pitch_out), .prec_yaw_out(prec_yaw_out),
		.time_tag_out(time_tag_out), .centre_index(centre_index), .status(status)
	);

	always #4 clk = ~clk;

	// shadow state of the filter
	logic signed [31:0] tap_mem [NTAPS];
	logic [5:0][31:0]   rec_mem [NREC];
	logic [63:0]        tag_mem [NREC];
	bit                 rec_written [NREC];
	logic [6:0]         tap_cnt_q;
	logic [12:0]        smp_cnt_q;

	filt_t filt_q [$];
	int    mismatches;
	int    results_seen;
	bit    no_idle;
	bit    hold_done;
	filt_t got, want;

	function automatic int used_samples();
		return (smp_cnt_q > NREC) ? NREC : int'(smp_cnt_q);
	endfunction

	function automatic int used_taps();
		int m;
		m = int'(tap_cnt_q);
		if (m > 0 && m % 2 == 0)
			m = m - 1;
		return m;
	endfunction

	// mirror: below zero without edge repeat, past the end with edge repeat
	function automatic int mirror_pos(int p, int n);
		if (p < 0)
			return -p;
		if (p >= n)
			return 2 * n - p - 1;
		return p;
	endfunction

	// round to nearest, ties away from zero, saturated to 32 bits
	function automatic logic [31:0] div_round_sat(logic signed [127:0] acc, longint tsum);
		logic [128:0] a_abs, d_abs, q;
		bit           neg;
		a_abs = acc[127] ? {1'b0, -acc} : {1'b0, acc};
		d_abs = (tsum < 0) ? 129'(-tsum) : 129'(tsum);
		neg   = acc[127] ^ (tsum < 0);
		q     = ((a_abs << 1) + d_abs) / (d_abs << 1);
		if (neg)
			return (q > 129'h80000000) ? 32'h80000000 : -q[31:0];
		return (q > 129'h7fffffff) ? 32'h7fffffff : q[31:0];
	endfunction

	// range status of a query at centre c, before the tap sum is looked at
	function automatic status_t range_status(int c);
		int n, m, h;
		n = used_samples();
		m = used_taps();
		h = m / 2;
		if (c >= n)
			return ST_RANGE;
		for (int k = 0; k < m; k++) begin
			if (mirror_pos(c + k - h, n) < 0 || mirror_pos(c + k - h, n) >= n)
				return ST_RANGE;
		end
		return ST_OK;
	endfunction

	// true when a query at c touches only records already loaded
	function automatic bit query_safe(int c);
		int n, m, h;
		n = used_samples();
		m = used_taps();
		h = m / 2;
		if (!rec_written[c])
			return 1'b0;
		if (range_status(c) != ST_OK)
			return 1'b1;
		for (int k = 0; k < m; k++) begin
			if (!rec_written[mirror_pos(c + k - h, n)])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic filt_t filter_query(int c);
		filt_t              r;
		int                 n, m, h, j;
		longint             tsum;
		logic signed [127:0] acc [6];
		longint             prod;
		n    = used_samples();
		m    = used_taps();
		h    = m / 2;
		tsum = 0;
		r.st = range_status(c);
		if (r.st == ST_OK) begin
			for (int k = 0; k < m; k++)
				tsum += longint'(tap_mem[k]);
			if (tsum == 0)
				r.st = ST_ZERO_SUM;
		end
		for (int ch = 0; ch < 6; ch++)
			acc[ch] = '0;
		if (r.st == ST_OK) begin
			for (int k = 0; k < m; k++) begin
				j = mirror_pos(c + k - h, n);
				for (int ch = 0; ch < 6; ch++) begin
					prod    = longint'(tap_mem[k]) * longint'($signed(rec_mem[j][ch]));
					acc[ch] = acc[ch] + 128'(signed'(prod));
				end
			end
		end
		for (int ch = 0; ch < 6; ch++)
			r.chan[ch] = (r.st == ST_OK) ? div_round_sat(acc[ch], tsum) : 32'd0;
		r.tag    = tag_mem[c];
		r.centre = 12'(c);
		return r;
	endfunction

	// update shadow state and expectations for one accepted item
	function automatic void absorb_item(stim_t s);
		filt_t r;
		case (s.md)
			MODE_TAP: tap_mem[s.tidx] = s.tval;
			MODE_REC: begin
				rec_mem[s.sidx]     = s.chan;
				tag_mem[s.sidx]     = s.tag;
				rec_written[s.sidx] = 1'b1;
			end
			MODE_QUERY: begin
				if (s.lit) begin
					r.chan   = '0;
					r.tag    = tag_mem[s.sidx];
					r.centre = s.sidx;
					r.st     = s.lit_st;
				end else
					r = filter_query(int'(s.sidx));
				filt_q.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'h00000000;
			default: return $urandom;
		endcase
	endfunction

	function automatic stim_t mk_item(mode_t md, int tidx, logic [31:0] tval, int sidx);
		stim_t s;
		s      = '0;
		s.kind = ROW_ITEM;
		s.md   = md;
		s.tidx = 7'(tidx);
		s.tval = tval;
		s.sidx = 12'(sidx);
		for (int ch = 0; ch < 6; ch++)
			s.chan[ch] = pick_word();
		s.tag  = {$urandom, $urandom};
		return s;
	endfunction

	function automatic stim_t mk_lit(int sidx, status_t st);
		stim_t s;
		s        = mk_item(MODE_QUERY, 0, 0, sidx);
		s.lit    = 1'b1;
		s.lit_st = st;
		return s;
	endfunction

	function automatic stim_t mk_cfg(logic [1:0] idx, int val);
		stim_t s;
		s         = '0;
		s.kind    = ROW_CFG;
		s.reg_idx = idx;
		s.reg_val = 13'(val);
		return s;
	endfunction

	// one transfer on the input channel, then an optional gap
	task automatic send_item(stim_t s);
		int g;
		in_valid     <= 1'b1;
		mode         <= s.md;
		tap_index    <= s.tidx;
		tap_value    <= s.tval;
		sample_index <= s.sidx;
		sat_roll     <= s.chan[0];
		sat_pitch    <= s.chan[1];
		sat_yaw      <= s.chan[2];
		prec_roll    <= s.chan[3];
		prec_pitch   <= s.chan[4];
		prec_yaw     <= s.chan[5];
		time_tag     <= s.tag;
		do @(posedge clk); while (!in_ready);
		absorb_item(s);
		g = no_idle ? 0 : pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// register write once every query has come back
	task automatic write_reg(stim_t s);
		in_valid <= 1'b0;
		@(posedge clk);
		while (filt_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= s.reg_idx;
		cfg_data  <= s.reg_val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (s.reg_idx == CFG_TAP_COUNT)
			tap_cnt_q = s.reg_val[6:0];
		else if (s.reg_idx == CFG_SAMPLE_COUNT)
			smp_cnt_q = s.reg_val;
	endtask

	task automatic run_row(stim_t s);
		if (s.kind == ROW_CFG)
			write_reg(s);
		else
			send_item(s);
	endtask

	// random item of one phase: taps, records, dropped items and queries on loaded records
	function automatic stim_t random_item();
		int    r, c, n;
		logic [31:0] tv;
		n = used_samples();
		r = $urandom_range(0, 99);
		if (r < 25) begin
			tv = ($urandom_range(0, 3) == 0) ? pick_word() : 32'($urandom_range(0, 1 << 28));
			return mk_item(MODE_TAP, $urandom_range(0, NTAPS - 1), tv, 0);
		end
		if (r < 45) begin
			c = ($urandom_range(0, 1) == 0) ? $urandom_range(0, NREC - 1) :
				(($urandom_range(0, 1) == 0) ? $urandom_range(0, 63) :
				$urandom_range(NREC - 64, NREC - 1));
			return mk_item(MODE_REC, 0, 0, c);
		end
		if (r < 48)
			return mk_item(MODE_NONE, $urandom_range(0, 127), $urandom, $urandom_range(0, 4095));
		case ($urandom_range(0, 9))
			0, 1, 2, 3: c = $urandom_range(0, NREC - 1);
			4, 5, 6:    c = $urandom_range(0, (n < 16) ? n - 1 : 15);
			7, 8:       c = n - 1 - $urandom_range(0, (n < 16) ? n - 1 : 15);
			default:    c = $urandom_range(n - 1, NREC - 1);
		endcase
		if (!query_safe(c))
			return mk_item(MODE_REC, 0, 0, c);
		return mk_item(MODE_QUERY, 0, 0, c);
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			got.chan = {prec_yaw_out, prec_pitch_out, prec_roll_out,
				sat_yaw_out, sat_pitch_out, sat_roll_out};
			got.tag    = time_tag_out;
			got.centre = centre_index;
			got.st     = status_t'(status);
			if (filt_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result at centre %0d", centre_index);
			end else begin
				want = filt_q.pop_front();
				if (got.chan !== want.chan || got.tag !== want.tag ||
					got.centre !== want.centre || got.st !== want.st) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch centre exp %0d got %0d status exp %0d got %0d",
							want.centre, got.centre, want.st, got.st);
						$display("  chan exp %h got %h", want.chan, got.chan);
						$display("  tag exp %h got %h", want.tag, got.tag);
					end
				end
			end
		end
	end

	// receiver with random stalls and one long hold-off
	initial begin
		int g;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && results_seen >= 40) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
			end else begin
				g = pick_gap();
				if (g > 0) begin
					out_ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// run limit
	initial begin
		#40_000_000;
		$display("FAILURE");
		$finish;
	end

	// stimulus
	initial begin
		stim_t rows [$];
		stim_t s;
		int    tc, sc;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = MODE_NONE;
		tap_index    = '0;
		tap_value    = '0;
		sample_index = '0;
		sat_roll     = '0;
		sat_pitch    = '0;
		sat_yaw      = '0;
		prec_roll    = '0;
		prec_pitch   = '0;
		prec_yaw     = '0;
		time_tag     = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_TAP_COUNT;
		cfg_data     = '0;
		mismatches   = 0;
		results_seen = 0;
		no_idle      = 1'b0;
		hold_done    = 1'b0;
		tap_cnt_q    = 7'd1;
		smp_cnt_q    = 13'd1;
		for (int i = 0; i < NREC; i++)
			rec_written[i] = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load every tap and both ends of the record store
		for (int i = 0; i < NTAPS; i++)
			send_item(mk_item(MODE_TAP, i, 32'($urandom_range(0, 1 << 26)), 0));
		for (int i = 0; i < 64; i++) begin
			send_item(mk_item(MODE_REC, 0, 0, i));
			send_item(mk_item(MODE_REC, 0, 0, NREC - 1 - i));
		end

		// directed table
		rows.push_back(mk_item(MODE_QUERY, 0, 0, 0));
		rows.push_back(mk_lit(5, ST_RANGE));
		rows.push_back(mk_item(MODE_NONE, 127, 32'hffffffff, 4095));
		rows.push_back(mk_item(MODE_TAP, 127, 32'h7fffffff, 0));
		rows.push_back(mk_item(MODE_TAP, 0, 32'h80000000, 0));
		s = mk_item(MODE_REC, 0, 0, 4095);
		s.chan = {6{32'h7fffffff}};
		s.tag  = '1;
		rows.push_back(s);
		s = mk_item(MODE_REC, 0, 0, 0);
		s.chan = {6{32'h80000000}};
		s.tag  = '0;
		rows.push_back(s);
		rows.push_back(mk_item(MODE_QUERY, 0, 0, 0));
		rows.push_back(mk_cfg(CFG_SAMPLE_COUNT, 8191));
		rows.push_back(mk_cfg(CFG_TAP_COUNT, 0));
		rows.push_back(mk_lit(4095, ST_ZERO_SUM));
		rows.push_back(mk_cfg(CFG_TAP_COUNT, 3));
		rows.push_back(mk_item(MODE_TAP, 0, 32'h40000000, 0));
		rows.push_back(mk_item(MODE_TAP, 1, 32'hc0000000, 0));
		rows.push_back(mk_item(MODE_TAP, 2, 32'h00000000, 0));
		rows.push_back(mk_lit(10, ST_ZERO_SUM));
		// tap sum of one: quotient far beyond 32 bits
		rows.push_back(mk_item(MODE_TAP, 1, 32'hc0000001, 0));
		rows.push_back(mk_item(MODE_QUERY, 0, 0, 1));
		rows.push_back(mk_cfg(CFG_SAMPLE_COUNT, 1));
		rows.push_back(mk_lit(0, ST_RANGE));
		rows.push_back(mk_cfg(CFG_TAP_COUNT, 0));
		rows.push_back(mk_lit(5, ST_RANGE));
		rows.push_back(mk_cfg(CFG_TAP_COUNT, 2));
		rows.push_back(mk_cfg(CFG_SAMPLE_COUNT, 64));
		rows.push_back(mk_item(MODE_TAP, 0, 32'h10000000, 0));
		rows.push_back(mk_item(MODE_QUERY, 0, 0, 63));
		rows.push_back(mk_cfg(CFG_TAP_COUNT, 127));
		rows.push_back(mk_item(MODE_QUERY, 0, 0, 0));
		rows.push_back(mk_item(MODE_QUERY, 0, 0, 63));
		rows.push_back(mk_cfg(2'd3, 5));
		rows.push_back(mk_cfg(CFG_TAP_COUNT, 5));
		rows.push_back(mk_cfg(CFG_SAMPLE_COUNT, 4096));
		rows.push_back(mk_item(MODE_QUERY, 0, 0, 4095));
		foreach (rows[i])
			run_row(rows[i]);

		// random phases with fresh register settings
		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 9))
				0:       tc = 127;
				1:       tc = 2 * $urandom_range(1, 10);
				2:       tc = 0;
				3:       tc = $urandom_range(0, 127);
				default: tc = 2 * $urandom_range(0, 7) + 1;
			endcase
			case ($urandom_range(0, 9))
				0, 1:    sc = 4096;
				2:       sc = $urandom_range(4097, 8191);
				3, 4, 5: sc = $urandom_range(1, 4096);
				default: sc = $urandom_range(1, 64);
			endcase
			run_row(mk_cfg(CFG_TAP_COUNT, tc));
			run_row(mk_cfg(CFG_SAMPLE_COUNT, sc));
			no_idle = (ph % 4 == 3);
			for (int i = 0; i < 125; i++)
				send_item(random_item());
		end

		// drain
		in_valid <= 1'b0;
		@(posedge clk);
		while (filt_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && filt_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
src/fmbf_pkg.sv
src/fmbf_ram.sv
src/fmbf_lane.sv
src/fir_mirror_boundary_filter.sv
test/fir_mirror_boundary_filter_tb.sv
